FILE: design/avcc_to_annexb_converter_assert.svh
// assertion macros shared by the converter checker
`ifndef AVCC_TO_ANNEXB_CONVERTER_ASSERT_SVH
`define AVCC_TO_ANNEXB_CONVERTER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define A2B_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define A2B_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/a2b_pkg.sv
// shared types and constants of the avcc to annex b converter
package a2b_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int MAX_ITEMS   = 4;
    localparam int Q_DEPTH     = 8;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = Q_AW + 1;

    localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
    localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_NONE  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [23:0] total_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_packet;
        logic       keyframe;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [2:0]                     count;
        t_out_item [MAX_ITEMS-1:0]      items;
    } t_push;

endpackage

FILE: design/a2b_core.sv
// input register and per-byte conversion step
module a2b_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  a2b_pkg::t_in_item i_item,
    output logic              o_stall,
    input  logic              i_room,
    output a2b_pkg::t_push    o_push
);
    import a2b_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_PAY  = 2'd1,
        PH_DROP = 2'd2
    } t_phase;

    logic        r_in_valid;
    t_in_item    r_in;
    t_phase      r_phase,          n_phase;
    logic [23:0] r_len_shift,      n_len_shift;
    logic [1:0]  r_len_count,      n_len_count;
    logic [23:0] r_payload_left,   n_payload_left;
    logic [23:0] r_bytes_left,     n_bytes_left;
    logic        r_first_of_unit,  n_first_of_unit;
    logic        r_keyframe_seen,  n_keyframe_seen;
    logic        r_unit_emitted,   n_unit_emitted;
    logic        r_short_buffer,   n_short_buffer;
    logic        consume;
    t_push       push;

    assign consume = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign o_push  = push;

    always_comb begin
        logic [23:0] total;
        logic [23:0] remain;
        logic [31:0] n;
        logic [2:0]  k;
        t_status     st;

        n_phase         = r_phase;
        n_len_shift     = r_len_shift;
        n_len_count     = r_len_count;
        n_payload_left  = r_payload_left;
        n_bytes_left    = r_bytes_left;
        n_first_of_unit = r_first_of_unit;
        n_keyframe_seen = r_keyframe_seen;
        n_unit_emitted  = r_unit_emitted;
        n_short_buffer  = r_short_buffer;
        k               = 3'd0;
        push            = '0;
        total           = r_in.total_length;
        st              = ST_OK;

        // a new buffer drops whatever was left of the old one
        if (r_in.first_byte) begin
            if (total == 24'd0) begin
                total = 24'd1;
            end
            n_bytes_left    = total;
            n_phase         = PH_LEN;
            n_len_shift     = '0;
            n_len_count     = '0;
            n_payload_left  = '0;
            n_first_of_unit = 1'b0;
            n_keyframe_seen = 1'b0;
            n_unit_emitted  = 1'b0;
            n_short_buffer  = (total < 24'd4);
        end

        remain = n_bytes_left - 24'd1;
        n      = {n_len_shift, r_in.data_byte};

        if (n_bytes_left != 24'd0) begin
            case (n_phase)
                PH_LEN: begin
                    if (n_len_count == 2'd3) begin
                        n_len_shift = '0;
                        n_len_count = '0;
                        if (n == 32'd0 || n > {8'd0, remain} || (n >> LENGTH_BITS) != 32'd0) begin
                            n_phase = PH_DROP;
                        end else begin
                            push.items[0] = '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK};
                            push.items[1] = '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK};
                            push.items[2] = '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK};
                            push.items[3] = '{8'h01, 1'b1, 1'b0, 1'b0, ST_OK};
                            k               = 3'd4;
                            n_payload_left  = n[23:0];
                            n_first_of_unit = 1'b1;
                            n_unit_emitted  = 1'b1;
                            n_phase         = PH_PAY;
                        end
                    end else begin
                        n_len_shift = n[23:0];
                        n_len_count = n_len_count + 2'd1;
                    end
                end
                PH_PAY: begin
                    push.items[0] = '{r_in.data_byte, 1'b1, 1'b0, 1'b0, ST_OK};
                    k = 3'd1;
                    if (n_first_of_unit &&
                        (r_in.data_byte[4:0] & NAL_TYPE_MASK) == NAL_TYPE_IDR) begin
                        n_keyframe_seen = 1'b1;
                    end
                    n_first_of_unit = 1'b0;
                    if (n_payload_left != 24'd0) begin
                        n_payload_left = n_payload_left - 24'd1;
                    end
                    if (n_payload_left == 24'd0) begin
                        n_phase = PH_LEN;
                    end
                end
                default: begin
                end
            endcase

            n_bytes_left = remain;
            // last byte of the buffer: the status item follows any data item
            if (remain == 24'd0) begin
                if (n_short_buffer) begin
                    st = ST_SHORT;
                end else if (n_unit_emitted) begin
                    st = ST_OK;
                end else begin
                    st = ST_NONE;
                end
                push.items[k[1:0]] = '{8'h00, 1'b0, 1'b1, n_keyframe_seen, st};
                k               = k + 3'd1;
                n_phase         = PH_LEN;
                n_len_shift     = '0;
                n_len_count     = '0;
                n_payload_left  = '0;
                n_first_of_unit = 1'b0;
            end
        end

        push.count = consume ? k : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_phase         <= PH_LEN;
            r_len_shift     <= '0;
            r_len_count     <= '0;
            r_payload_left  <= '0;
            r_bytes_left    <= '0;
            r_first_of_unit <= 1'b0;
            r_keyframe_seen <= 1'b0;
            r_unit_emitted  <= 1'b0;
            r_short_buffer  <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (consume) begin
                r_phase         <= n_phase;
                r_len_shift     <= n_len_shift;
                r_len_count     <= n_len_count;
                r_payload_left  <= n_payload_left;
                r_bytes_left    <= n_bytes_left;
                r_first_of_unit <= n_first_of_unit;
                r_keyframe_seen <= n_keyframe_seen;
                r_unit_emitted  <= n_unit_emitted;
                r_short_buffer  <= n_short_buffer;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in <= i_item;
        end
    end

endmodule

FILE: design/a2b_queue.sv
// result queue taking up to four items per cycle and giving one unless stalled
module a2b_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  a2b_pkg::t_push     i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_stall,
    output a2b_pkg::t_out_item o_item
);
    import a2b_pkg::*;

    t_out_item         r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_CW-1:0]   r_count;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;
    // room for a whole start code, whatever leaves this cycle
    assign o_room  = (r_count <= Q_CW'(Q_DEPTH - MAX_ITEMS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_AW'(i_push.count);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_count <= r_count + Q_CW'(i_push.count) - Q_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if (i < int'(i_push.count)) begin
                r_mem[r_wr_ptr + Q_AW'(i)] <= i_push.items[i];
            end
        end
    end

endmodule

FILE: design/avcc_to_annexb_converter.sv
// top level of the avcc to annex b byte converter
// input channel: i_valid / o_stall carry one item per cycle unless stalled:
//   a byte, a first-byte flag and, on the first byte, the buffer's byte count
// output channel: o_valid / i_stall carry one result per cycle unless stalled:
//   start code or payload bytes, and one status item per completed buffer
// an accepted item waits in the input register until the queue has room,
//   then its results are written to an 8-entry queue, whose head drives the
//   output and can be taken when the receiver does not stall
// throughput is one item per cycle in and out when nothing stalls; the fourth
//   length byte makes four start-code items at once, which the queue absorbs
//   as the other three length bytes of the unit produce nothing
// the input stalls while an item waits and the queue has fewer than four free
//   entries, so a stalled receiver fills the queue and then holds off the sender
// reset empties the queue and the input register and clears the buffer state;
//   a byte with no buffer open is taken and dropped
module avcc_to_annexb_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  a2b_pkg::t_in_item  i_item,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output a2b_pkg::t_out_item o_item
);
    import a2b_pkg::*;

    t_push push;
    logic  room;

    a2b_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .i_room  (room),
        .o_push  (push)
    );

    a2b_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

FILE: design/a2b_checker.sv
// port-level checker for the converter, bound to the top level
`include "avcc_to_annexb_converter_assert.svh"

module a2b_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input a2b_pkg::t_out_item o_item
);
    import a2b_pkg::*;

    logic status_ok;
    logic data_ok;

    // a status item carries no byte and one of the defined status codes
    assign status_ok = !o_item.byte_valid && o_item.out_byte == 8'h00 &&
                       (o_item.status == ST_OK || o_item.status == ST_SHORT ||
                        o_item.status == ST_NONE);
    assign data_ok   = o_item.byte_valid && !o_item.keyframe && o_item.status == ST_OK;

    `A2B_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid, "item dropped while stalled")
    `A2B_ASSERT_NXT(a_out_stable, o_valid && i_stall, $stable(o_item), "stalled item changed")
    `A2B_ASSERT_IMP(a_status_item, o_valid && o_item.end_of_packet, status_ok, "bad status item")
    `A2B_ASSERT_IMP(a_data_item, o_valid && !o_item.end_of_packet, data_ok, "bad data item")

endmodule

bind avcc_to_annexb_converter a2b_checker u_a2b_checker (.*);

FILE: test/tb.sv
// testbench of the avcc to annex b byte converter: predictor, stimulus and result checks
`timescale 1ns / 1ps

import a2b_pkg::*;

class annexb_scoreboard;
    typedef enum logic [1:0] {
        SCAN_LENGTH  = 2'd0,
        PASS_PAYLOAD = 2'd1,
        DROP_REST    = 2'd2
    } t_scan_phase;

    t_out_item   pending_annexb[$];
    int          errors;
    int          items_checked;
    int          buffers_closed;
    int          keyframe_buffers;

    t_scan_phase phase;
    logic [31:0] length_shift;
    logic [1:0]  length_count;
    logic [23:0] payload_left;
    logic [23:0] bytes_left;
    logic        first_of_unit;
    logic        keyframe_seen;
    logic        unit_emitted;
    logic        short_buffer;

    function new();
        phase         = SCAN_LENGTH;
        length_shift  = '0;
        length_count  = '0;
        payload_left  = '0;
        bytes_left    = '0;
        first_of_unit = 1'b0;
        keyframe_seen = 1'b0;
        unit_emitted  = 1'b0;
        short_buffer  = 1'b0;
    endfunction

    function int pending();
        return pending_annexb.size();
    endfunction

    function void push_annexb(logic [7:0] b, logic v, logic e, logic kf, t_status st);
        t_out_item item;
        item = '{out_byte: b, byte_valid: v, end_of_packet: e, keyframe: kf, status: st};
        pending_annexb.push_back(item);
    endfunction

    // returns 1 when the byte belongs to an open buffer
    function bit accept_avcc_byte(t_in_item it);
        logic [23:0] total;
        logic [23:0] remain;
        logic [31:0] unit_len;
        total = it.total_length;
        if (it.first_byte) begin
            if (total == 24'd0) total = 24'd1;
            bytes_left    = total;
            phase         = SCAN_LENGTH;
            length_shift  = '0;
            length_count  = '0;
            payload_left  = '0;
            first_of_unit = 1'b0;
            keyframe_seen = 1'b0;
            unit_emitted  = 1'b0;
            short_buffer  = (total < 24'd4);
        end
        if (bytes_left == 24'd0) return 1'b0;
        remain = bytes_left - 24'd1;

        case (phase)
            SCAN_LENGTH: begin
                length_shift = {length_shift[23:0], it.data_byte};
                if (length_count == 2'd3) begin
                    unit_len     = length_shift;
                    length_count = '0;
                    length_shift = '0;
                    if (unit_len == 32'd0 || unit_len > remain ||
                        (unit_len >> LENGTH_BITS) != 0) begin
                        phase = DROP_REST;
                    end else begin
                        push_annexb(8'h00, 1'b1, 1'b0, 1'b0, ST_OK);
                        push_annexb(8'h00, 1'b1, 1'b0, 1'b0, ST_OK);
                        push_annexb(8'h00, 1'b1, 1'b0, 1'b0, ST_OK);
                        push_annexb(8'h01, 1'b1, 1'b0, 1'b0, ST_OK);
                        payload_left  = unit_len[23:0];
                        first_of_unit = 1'b1;
                        unit_emitted  = 1'b1;
                        phase         = PASS_PAYLOAD;
                    end
                end else begin
                    length_count++;
                end
            end
            PASS_PAYLOAD: begin
                push_annexb(it.data_byte, 1'b1, 1'b0, 1'b0, ST_OK);
                if (first_of_unit && (it.data_byte[4:0] & NAL_TYPE_MASK) == NAL_TYPE_IDR)
                    keyframe_seen = 1'b1;
                first_of_unit = 1'b0;
                if (payload_left > 0) payload_left--;
                if (payload_left == 0) phase = SCAN_LENGTH;
            end
            default: ;
        endcase

        bytes_left = remain;
        if (bytes_left == 24'd0) begin
            push_annexb(8'h00, 1'b0, 1'b1, keyframe_seen,
                        short_buffer ? ST_SHORT : (unit_emitted ? ST_OK : ST_NONE));
            phase         = SCAN_LENGTH;
            length_shift  = '0;
            length_count  = '0;
            payload_left  = '0;
            first_of_unit = 1'b0;
        end
        return 1'b1;
    endfunction

    function void report(string field, int expd, int got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, expd, got);
    endfunction

    function void check_annexb_item(t_out_item got);
        t_out_item expd;
        if (pending_annexb.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, got %h", $time, got);
            return;
        end
        expd = pending_annexb.pop_front();
        items_checked++;
        if (expd.end_of_packet) begin
            buffers_closed++;
            if (expd.keyframe) keyframe_buffers++;
        end
        if (got.out_byte !== expd.out_byte)
            report("out_byte", expd.out_byte, got.out_byte);
        if (got.byte_valid !== expd.byte_valid)
            report("byte_valid", expd.byte_valid, got.byte_valid);
        if (got.end_of_packet !== expd.end_of_packet)
            report("end_of_packet", expd.end_of_packet, got.end_of_packet);
        if (got.keyframe !== expd.keyframe)
            report("keyframe", expd.keyframe, got.keyframe);
        if (got.status !== expd.status)
            report("status", expd.status, got.status);
    endfunction
endclass

module tb;
    localparam int TARGET_BYTES   = 360;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES  = 8;
    localparam int STUCK_LIMIT    = 2000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    t_in_item  i_item;
    logic      o_stall;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    annexb_scoreboard sb = new;

    int active_bytes;
    int stuck_cycles;
    int rx_hold_left;
    bit rx_hold_req;
    bit quiet;

    avcc_to_annexb_converter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_item       = '0;
        i_stall      = 1'b0;
        active_bytes = 0;
        stuck_cycles = 0;
        rx_hold_left = 0;
        rx_hold_req  = 1'b0;
        quiet        = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            if (sb.accept_avcc_byte(i_item)) active_bytes <= active_bytes + 1;
        end
        if (i_rst_n && o_valid && !i_stall) sb.check_annexb_item(o_item);
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 9);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_avcc(input logic [7:0] data, input logic first,
                             input logic [23:0] total);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= '{data_byte: data, first_byte: first, total_length: total};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // total length rides on the first byte only, other bytes carry noise there
    task automatic send_buffer(input logic [7:0] avcc[$], input logic [23:0] total);
        foreach (avcc[i])
            send_avcc(avcc[i], i == 0, (i == 0) ? total : 24'($urandom));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_random_buffer();
        logic [7:0]  avcc[$];
        logic [31:0] unit_len;
        logic [23:0] total;
        int          pick;
        int          r;
        pick = $urandom_range(99);
        if (pick >= 95) begin
            // stray bytes, ignored unless an earlier buffer is still open
            repeat ($urandom_range(1, 3)) send_avcc(8'($urandom), 1'b0, 24'($urandom));
            return;
        end
        if (pick >= 90) begin
            repeat ($urandom_range(1, 3)) avcc.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3)) begin
                r = $urandom_range(99);
                unit_len = (r < 5) ? 32'd0 : (r < 10) ? 32'($urandom_range(20, 64))
                                                      : 32'($urandom_range(1, 8));
                avcc.push_back(unit_len[31:24]);
                avcc.push_back(unit_len[23:16]);
                avcc.push_back(unit_len[15:8]);
                avcc.push_back(unit_len[7:0]);
                for (int i = 0; i < unit_len; i++)
                    avcc.push_back((i == 0 && $urandom_range(2) == 0) ?
                                   {3'($urandom), NAL_TYPE_IDR} : 8'($urandom));
            end
            repeat ($urandom_range(0, 3)) avcc.push_back(8'($urandom));
            // garbage length word, mostly too wide
            if (pick >= 85)
                for (int i = 0; i < 4; i++) avcc[i] = 8'($urandom);
        end
        total = 24'(avcc.size());
        if (pick >= 70 && pick < 78 && avcc.size() > 4)
            total = total - 24'($urandom_range(1, 3));
        else if (pick >= 78 && pick < 85)
            total = total + 24'($urandom_range(1, 5));
        send_buffer(avcc, total);
    endtask

    initial begin
        logic [7:0] avcc[$];
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // byte with no buffer open
        send_avcc(8'hff, 1'b0, 24'hffffff);
        // zero total length closes at once as short
        send_avcc(8'h00, 1'b1, 24'd0);
        // length wider than the length field, then abandoned by a new buffer
        avcc = '{8'h01, 8'h00, 8'h00, 8'h00};
        send_buffer(avcc, 24'hffffff);
        // one keyframe unit whose last byte also closes the buffer
        avcc = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h25};
        send_buffer(avcc, 24'd5);
        // zero length
        avcc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'haa};
        send_buffer(avcc, 24'd5);
        // length overruns the buffer
        avcc = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h33};
        send_buffer(avcc, 24'd5);
        // type 5 only on a later byte, short tail ignored
        avcc = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h41, 8'h85, 8'h77};
        send_buffer(avcc, 24'd7);
        wait_drained();

        // receiver holds off while the sender keeps offering a long buffer
        @(posedge i_clk);
        rx_hold_req = 1'b1;
        avcc = {};
        repeat (3) begin
            avcc.push_back(8'h00);
            avcc.push_back(8'h00);
            avcc.push_back(8'h00);
            avcc.push_back(8'h08);
            repeat (8) avcc.push_back(8'($urandom));
        end
        send_buffer(avcc, 24'(avcc.size()));
        wait_drained();

        while (active_bytes < TARGET_BYTES) begin
            quiet = (active_bytes >= 200 && active_bytes < 270);
            send_random_buffer();
        end
        quiet = 1'b0;
        wait_drained();

        $display("sent %0d buffer bytes, checked %0d output items", active_bytes,
                 sb.items_checked);
        $display("closed %0d buffers, %0d of them keyframes", sb.buffers_closed,
                 sb.keyframe_buffers);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
